[hdl/dpq_pkg.sv]
// shared types and constants for the double-ended priority queue
`default_nettype none

package dpq_pkg;

  localparam int DATA_W           = 32;
  localparam int COUNT_OUT_W      = 9;
  localparam int DEFAULT_CAPACITY = 256;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_MAX = 2'd1,
    OP_DEL_MIN = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  // command broadcast to every cell of one chain
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_INSERT    = 3'd1,
    CMD_POP_FRONT = 3'd2,
    CMD_POP_BACK  = 3'd3,
    CMD_CLEAR     = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                 cmd;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic signed [DATA_W-1:0]  val;
    logic                      occ;
    logic                      place;
  } nbr_t;

endpackage

`default_nettype wire

[hdl/dpq_cell.sv]
// one storage cell of a sorted chain
`default_nettype none

module dpq_cell
  import dpq_pkg::*;
#(
  parameter bit DESCENDING = 1'b0
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire nbr_t      prev,
  input  wire nbr_t      next,
  output nbr_t           self
);

  logic signed [DATA_W-1:0] val;
  logic                     occ;
  logic                     beyond;

  // this cell lies at or after the insertion point
  always_comb begin
    if (DESCENDING) begin
      beyond = val < ctl.value;
    end else begin
      beyond = val > ctl.value;
    end
  end

  assign self.val   = val;
  assign self.occ   = occ;
  assign self.place = !occ || beyond;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      case (ctl.cmd)
        CMD_INSERT:    occ <= occ || prev.occ;
        CMD_POP_FRONT: occ <= next.occ;
        CMD_POP_BACK:  occ <= next.occ;
        CMD_CLEAR:     occ <= 1'b0;
        default:       occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_INSERT: begin
        if (self.place) begin
          val <= prev.place ? prev.val : ctl.value;
        end
      end
      CMD_POP_FRONT: val <= next.val;
      default:       val <= val;
    endcase
  end

endmodule

`default_nettype wire

[hdl/dpq_chain.sv]
// row of sorted cells; the head cell holds the extreme value
`default_nettype none

module dpq_chain
  import dpq_pkg::*;
#(
  parameter int CAPACITY   = DEFAULT_CAPACITY,
  parameter bit DESCENDING = 1'b0
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cell_ctl_t                ctl,
  output logic signed [DATA_W-1:0]      head_val,
  output logic                          head_occ
);

  nbr_t cells [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    nbr_t prev;
    nbr_t next;

    if (i == 0) begin : g_first
      assign prev = '{val: '0, occ: 1'b1, place: 1'b0};
    end else begin : g_mid
      assign prev = cells[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next = '{val: cells[i].val, occ: 1'b0, place: 1'b1};
    end else begin : g_inner
      assign next = cells[i+1];
    end

    dpq_cell #(
      .DESCENDING(DESCENDING)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .prev (prev),
      .next (next),
      .self (cells[i])
    );
  end

  assign head_val = cells[0].val;
  assign head_occ = cells[0].occ;

endmodule

`default_nettype wire

[hdl/double_ended_priority_queue.sv]
// Bounded double-ended priority queue of signed 32-bit values.
// Input channel (in_valid/in_ready) carries opcode and value: insert,
// delete maximum, delete minimum, clear. Every item gives one result on
// the output channel (out_valid/out_ready): max_value, min_value,
// is_empty, entry_count and dropped_full, all as they stand after the item.
// The entries live twice, in an ascending and a descending chain of cells;
// every cell updates from its neighbors together, so the minimum and
// maximum are always the heads of the two chains.
// From acceptance to out_valid, the chains shift first and then the head values
// are registered. Throughput is one item per cycle while the receiver keeps
// out_ready high.
// When the receiver stalls, one finished item waits in the output register
// and a second one holds in the chains; after that in_ready drops until
// the output register is taken.
// Reset empties the queue at once (no clearing pass); stored values are
// not cleared, only the occupancy bits.
`default_nettype none

module double_ended_priority_queue
  import dpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    opcode,
  input  wire logic signed [DATA_W-1:0]      value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [DATA_W-1:0]           max_value,
  output logic signed [DATA_W-1:0]           min_value,
  output logic                               is_empty,
  output logic [COUNT_OUT_W-1:0]             entry_count,
  output logic                               dropped_full
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]             count;
  logic                      pend;
  logic                      pend_drop;
  logic                      accept;
  logic                      move;
  logic                      full;
  logic                      drop;
  cell_ctl_t                 asc_ctl;
  cell_ctl_t                 desc_ctl;
  logic signed [DATA_W-1:0]  asc_head;
  logic signed [DATA_W-1:0]  desc_head;
  logic                      asc_occ;
  logic                      desc_occ;

  assign move     = pend && (!out_valid || out_ready);
  assign in_ready = !pend || move;
  assign accept   = in_valid && in_ready;
  assign full     = count == CW'(CAPACITY);

  always_comb begin
    asc_ctl.value  = value;
    desc_ctl.value = value;
    asc_ctl.cmd    = CMD_NONE;
    desc_ctl.cmd   = CMD_NONE;
    drop           = 1'b0;
    if (accept) begin
      unique case (opcode_t'(opcode))
        OP_INSERT: begin
          if (full) begin
            drop = 1'b1;
          end else begin
            asc_ctl.cmd  = CMD_INSERT;
            desc_ctl.cmd = CMD_INSERT;
          end
        end
        OP_DEL_MAX: begin
          asc_ctl.cmd  = CMD_POP_BACK;
          desc_ctl.cmd = CMD_POP_FRONT;
        end
        OP_DEL_MIN: begin
          asc_ctl.cmd  = CMD_POP_FRONT;
          desc_ctl.cmd = CMD_POP_BACK;
        end
        OP_CLEAR: begin
          asc_ctl.cmd  = CMD_CLEAR;
          desc_ctl.cmd = CMD_CLEAR;
        end
        default: begin
          asc_ctl.cmd  = CMD_NONE;
          desc_ctl.cmd = CMD_NONE;
        end
      endcase
    end
  end

  dpq_chain #(
    .CAPACITY   (CAPACITY),
    .DESCENDING (1'b0)
  ) u_asc (
    .clk      (clk),
    .rst      (rst),
    .ctl      (asc_ctl),
    .head_val (asc_head),
    .head_occ (asc_occ)
  );

  dpq_chain #(
    .CAPACITY   (CAPACITY),
    .DESCENDING (1'b1)
  ) u_desc (
    .clk      (clk),
    .rst      (rst),
    .ctl      (desc_ctl),
    .head_val (desc_head),
    .head_occ (desc_occ)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (asc_ctl.cmd) inside
        CMD_INSERT: count <= count + 1'b1;
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (count != '0) begin
            count <= count - 1'b1;
          end
        end
        CMD_CLEAR: count <= '0;
        default:   count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_drop <= drop;
    end
    // chains already hold the state after the pending item
    if (move) begin
      max_value    <= desc_occ ? desc_head : '0;
      min_value    <= asc_occ ? asc_head : '0;
      is_empty     <= count == '0;
      entry_count  <= COUNT_OUT_W'(count);
      dropped_full <= pend_drop;
    end
  end

`ifndef SYNTHESIS
  a_heads_agree: assert property (@(posedge clk) disable iff (rst)
    asc_occ == desc_occ)
    else $error("ascending and descending chains disagree on occupancy");

  a_count_occ: assert property (@(posedge clk) disable iff (rst)
    asc_occ == (count != '0))
    else $error("head occupancy does not match entry count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pend && !move |-> !accept)
    else $error("item accepted while pending result is stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_empty |-> max_value >= min_value)
    else $error("reported maximum below reported minimum");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");
`endif

endmodule

`default_nettype wire
